// File: design/rci_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ray versus infinite cylinder intersection block.
// No dependencies; every other design file imports this package.
package rci_pkg;

  // Field widths of a transaction.
  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int DIST_W    = 31;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Internal arithmetic widths.
  localparam int WORD_W    = 64;
  localparam int DISC_W    = 126;
  localparam int SQRT_BITS = 63;
  localparam int QUOT_BITS = 31;
  localparam int DIV_W     = 96;

  // Decoupling queue between the front and back halves.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = FIFO_AW + 1;

  // Classified ray handed from the front half to the back half.
  typedef struct packed {
    logic              miss;
    logic              hneg;
    logic [WORD_W-1:0] hmag;
    logic [WORD_W-1:0] a;
    logic [DISC_W-1:0] disc;
  } front_item_t;

endpackage

// File: design/rci_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for ray transactions and hit transactions.
// Depends on rci_pkg for field widths.
interface rci_ray_if import rci_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  dir_x;
  logic signed [COORD_W-1:0]  dir_y;
  logic signed [COORD_W-1:0]  orig_x;
  logic signed [COORD_W-1:0]  orig_y;
  logic        [RADIUS_W-1:0] radius;

  modport source (output valid, dir_x, dir_y, orig_x, orig_y, radius, input ready);
  modport sink   (input valid, dir_x, dir_y, orig_x, orig_y, radius, output ready);
endinterface

interface rci_hit_if import rci_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

// File: design/rci_front.sv
`timescale 1ns / 1ps
// Front half: accepts rays, forms a, h and the discriminant and flags misses.
// Depends on rci_pkg and rci_if; feeds the decoupling queue.
module rci_front import rci_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rci_ray_if.sink      in_ch,
  output logic         item_valid,
  output front_item_t  item,
  input  logic         item_ready
);

  typedef struct packed {
    logic               valid;
    logic signed [63:0] dxdx;
    logic signed [63:0] dydy;
    logic signed [63:0] oxdx;
    logic signed [63:0] oydy;
    logic signed [63:0] oxdy;
    logic signed [63:0] oydx;
    logic [61:0]        rr;
  } f1_t;

  typedef struct packed {
    logic               valid;
    logic [63:0]        a;
    logic signed [64:0] h;
    logic signed [64:0] x;
    logic [61:0]        rr;
  } f2_t;

  typedef struct packed {
    logic        valid;
    logic        a_zero;
    logic [63:0] a;
    logic        hneg;
    logic [63:0] hmag;
    logic [63:0] xmag;
    logic [61:0] rr;
  } f3_t;

  typedef struct packed {
    logic        valid;
    logic        a_zero;
    logic [63:0] a;
    logic        hneg;
    logic [63:0] hmag;
    logic [63:0] ar_ll;
    logic [63:0] ar_lh;
    logic [63:0] ar_hl;
    logic [61:0] ar_hh;
    logic [63:0] x_ll;
    logic [63:0] x_lh;
    logic [63:0] x_hh;
  } f4_t;

  typedef struct packed {
    logic         valid;
    logic         a_zero;
    logic [63:0]  a;
    logic         hneg;
    logic [63:0]  hmag;
    logic [127:0] ar2;
    logic [127:0] x2;
  } f5_t;

  f1_t f1_r, f1_nxt;
  f2_t f2_r, f2_nxt;
  f3_t f3_r, f3_nxt;
  f4_t f4_r, f4_nxt;
  f5_t f5_r, f5_nxt;
  logic        f6_valid_r, f6_valid_nxt;
  front_item_t f6_r, f6_nxt;
  logic        en;

  // The whole front pipe moves unless its last stage is blocked by a full queue.
  assign en          = !f6_valid_r || item_ready;
  assign in_ch.ready = en;
  assign item_valid  = f6_valid_r;
  assign item        = f6_r;

  // Stage 1: the six 32 by 32 products and the 31 by 31 radius square.
  always_comb begin
    f1_nxt.valid = in_ch.valid;
    f1_nxt.dxdx  = 64'(in_ch.dir_x) * 64'(in_ch.dir_x);
    f1_nxt.dydy  = 64'(in_ch.dir_y) * 64'(in_ch.dir_y);
    f1_nxt.oxdx  = 64'(in_ch.orig_x) * 64'(in_ch.dir_x);
    f1_nxt.oydy  = 64'(in_ch.orig_y) * 64'(in_ch.dir_y);
    f1_nxt.oxdy  = 64'(in_ch.orig_x) * 64'(in_ch.dir_y);
    f1_nxt.oydx  = 64'(in_ch.orig_y) * 64'(in_ch.dir_x);
    f1_nxt.rr    = 62'(in_ch.radius) * 62'(in_ch.radius);
  end

  // Stage 2: a, the dot product h and the cross product x.
  always_comb begin
    f2_nxt.valid = f1_r.valid;
    f2_nxt.a     = f1_r.dxdx + f1_r.dydy;
    f2_nxt.h     = 65'(f1_r.oxdx) + 65'(f1_r.oydy);
    f2_nxt.x     = 65'(f1_r.oxdy) - 65'(f1_r.oydx);
    f2_nxt.rr    = f1_r.rr;
  end

  // Stage 3: magnitudes of h and x, and the parallel-ray check.
  always_comb begin
    f3_nxt.valid  = f2_r.valid;
    f3_nxt.a_zero = (f2_r.a == '0);
    f3_nxt.a      = f2_r.a;
    f3_nxt.hneg   = f2_r.h[64];
    f3_nxt.hmag   = f2_r.h[64] ? 64'(-f2_r.h) : f2_r.h[63:0];
    f3_nxt.xmag   = f2_r.x[64] ? 64'(-f2_r.x) : f2_r.x[63:0];
    f3_nxt.rr     = f2_r.rr;
  end

  // Stage 4: partial products of a*r^2 and x^2 on 32-bit halves.
  always_comb begin
    f4_nxt.valid  = f3_r.valid;
    f4_nxt.a_zero = f3_r.a_zero;
    f4_nxt.a      = f3_r.a;
    f4_nxt.hneg   = f3_r.hneg;
    f4_nxt.hmag   = f3_r.hmag;
    f4_nxt.ar_ll  = 64'(f3_r.a[31:0])  * 64'(f3_r.rr[31:0]);
    f4_nxt.ar_lh  = 64'(f3_r.a[31:0])  * 64'(f3_r.rr[61:32]);
    f4_nxt.ar_hl  = 64'(f3_r.a[63:32]) * 64'(f3_r.rr[31:0]);
    f4_nxt.ar_hh  = 62'(64'(f3_r.a[63:32]) * 64'(f3_r.rr[61:32]));
    f4_nxt.x_ll   = 64'(f3_r.xmag[31:0])  * 64'(f3_r.xmag[31:0]);
    f4_nxt.x_lh   = 64'(f3_r.xmag[31:0])  * 64'(f3_r.xmag[63:32]);
    f4_nxt.x_hh   = 64'(f3_r.xmag[63:32]) * 64'(f3_r.xmag[63:32]);
  end

  // Stage 5: recombine the partial products into the two 128-bit terms.
  always_comb begin
    f5_nxt.valid  = f4_r.valid;
    f5_nxt.a_zero = f4_r.a_zero;
    f5_nxt.a      = f4_r.a;
    f5_nxt.hneg   = f4_r.hneg;
    f5_nxt.hmag   = f4_r.hmag;
    f5_nxt.ar2    = {2'b00, f4_r.ar_hh, f4_r.ar_ll}
                  + (128'(f4_r.ar_lh) << 32) + (128'(f4_r.ar_hl) << 32);
    f5_nxt.x2     = {f4_r.x_hh, f4_r.x_ll} + (128'(f4_r.x_lh) << 33);
  end

  // Stage 6: discriminant and the miss flag for a parallel ray or a negative discriminant.
  always_comb begin
    f6_valid_nxt = f5_r.valid;
    f6_nxt.miss  = f5_r.a_zero || (f5_r.ar2 < f5_r.x2);
    f6_nxt.hneg  = f5_r.hneg;
    f6_nxt.hmag  = f5_r.hmag;
    f6_nxt.a     = f5_r.a;
    f6_nxt.disc  = DISC_W'(f5_r.ar2 - f5_r.x2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.valid <= 1'b0;
      f2_r.valid <= 1'b0;
      f3_r.valid <= 1'b0;
      f4_r.valid <= 1'b0;
      f5_r.valid <= 1'b0;
      f6_valid_r <= 1'b0;
    end else if (en) begin
      f1_r       <= f1_nxt;
      f2_r       <= f2_nxt;
      f3_r       <= f3_nxt;
      f4_r       <= f4_nxt;
      f5_r       <= f5_nxt;
      f6_valid_r <= f6_valid_nxt;
      f6_r       <= f6_nxt;
    end
  end

endmodule

// File: design/rci_fifo.sv
`timescale 1ns / 1ps
// Short queue that decouples the front half from the back half.
// Depends on rci_pkg for the item type and depth.
module rci_fifo import rci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t push_data,
  output logic        can_push,
  input  logic        pop,
  output front_item_t pop_data,
  output logic        can_pop
);

  front_item_t              entries_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     do_push, do_pop;

  assign can_push = (count_r != CNT_W'(FIFO_DEPTH));
  assign can_pop  = (count_r != '0);
  assign do_push  = push && can_push;
  assign do_pop   = pop && can_pop;
  assign pop_data = entries_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/rci_back.sv
`timescale 1ns / 1ps
// Back half: pipelined square root, root selection, pipelined division and saturation.
// Depends on rci_pkg and rci_if; drains the decoupling queue.
module rci_back import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  front_item_t item,
  output logic        item_pop,
  rci_hit_if.source   out_ch
);

  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic                 hneg;
    logic [WORD_W-1:0]    hmag;
    logic [WORD_W-1:0]    a;
    logic [DISC_W-1:0]    rem;
    logic [SQRT_BITS-1:0] res;
  } sq_t;

  typedef struct packed {
    logic              valid;
    logic              miss;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] num;
  } num_t;

  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic                 sat;
    logic [WORD_W-1:0]    a;
    logic [DIV_W-1:0]     rem;
    logic [QUOT_BITS-1:0] quot;
  } dv_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DIST_W-1:0] distance;
  } res_t;

  sq_t  sq_chain [SQRT_BITS+1];
  dv_t  dv_chain [QUOT_BITS+1];
  num_t num_r, num_nxt;
  dv_t  sat_r, sat_nxt;
  res_t out_r, out_nxt;
  logic en;
  logic gneg;
  logic [WORD_W-1:0] s_ext;

  // The back pipe moves unless a finished result is waiting to be taken.
  assign en       = !out_r.valid || out_ch.ready;
  assign item_pop = en && item_valid;

  assign out_ch.valid    = out_r.valid;
  assign out_ch.hit      = out_r.hit;
  assign out_ch.distance = out_r.distance;

  // Square-root entry: remainder starts as the discriminant.
  always_comb begin
    sq_chain[0].valid = item_valid;
    sq_chain[0].miss  = item.miss;
    sq_chain[0].hneg  = item.hneg;
    sq_chain[0].hmag  = item.hmag;
    sq_chain[0].a     = item.a;
    sq_chain[0].rem   = item.disc;
    sq_chain[0].res   = '0;
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - k;
    sq_t          stage_r, stage_nxt;
    logic [127:0] trial;

    always_comb begin
      stage_nxt = sq_chain[k];
      trial     = (128'(sq_chain[k].res) << (B + 1)) | (128'd1 << (2 * B));
      if ({2'b00, sq_chain[k].rem} >= trial) begin
        stage_nxt.rem = sq_chain[k].rem - trial[DISC_W-1:0];
        stage_nxt.res = sq_chain[k].res | (SQRT_BITS'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (en) begin
        stage_r <= stage_nxt;
      end
    end

    assign sq_chain[k+1] = stage_r;
  end

  // Root selection: nearest numerator that is not negative.
  assign s_ext = WORD_W'(sq_chain[SQRT_BITS].res);
  assign gneg  = (sq_chain[SQRT_BITS].hmag != '0) && !sq_chain[SQRT_BITS].hneg;

  always_comb begin
    num_nxt.valid = sq_chain[SQRT_BITS].valid;
    num_nxt.a     = sq_chain[SQRT_BITS].a;
    num_nxt.miss  = sq_chain[SQRT_BITS].miss;
    num_nxt.num   = '0;
    if (!gneg) begin
      if (sq_chain[SQRT_BITS].hmag >= s_ext) begin
        num_nxt.num = sq_chain[SQRT_BITS].hmag - s_ext;
      end else begin
        num_nxt.num = sq_chain[SQRT_BITS].hmag + s_ext;
      end
    end else if (s_ext >= sq_chain[SQRT_BITS].hmag) begin
      num_nxt.num = s_ext - sq_chain[SQRT_BITS].hmag;
    end else begin
      num_nxt.miss = 1'b1;
    end
  end

  // Scale the numerator and detect a quotient that will not fit.
  always_comb begin
    sat_nxt.valid = num_r.valid;
    sat_nxt.miss  = num_r.miss;
    sat_nxt.a     = num_r.a;
    sat_nxt.rem   = DIV_W'(num_r.num) << FRAC_BITS;
    sat_nxt.sat   = (DIV_W'(num_r.num) << FRAC_BITS) >= (DIV_W'(num_r.a) << QUOT_BITS);
    sat_nxt.quot  = '0;
  end

  assign dv_chain[0] = sat_r;

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    localparam int Q = QUOT_BITS - 1 - k;
    dv_t              stage_r, stage_nxt;
    logic [DIV_W-1:0] dvs;

    always_comb begin
      stage_nxt = dv_chain[k];
      dvs       = DIV_W'(dv_chain[k].a) << Q;
      if (dv_chain[k].rem >= dvs) begin
        stage_nxt.rem  = dv_chain[k].rem - dvs;
        stage_nxt.quot = dv_chain[k].quot | (QUOT_BITS'(1) << Q);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (en) begin
        stage_r <= stage_nxt;
      end
    end

    assign dv_chain[k+1] = stage_r;
  end

  // Result register: miss, saturation or the quotient.
  always_comb begin
    out_nxt.valid    = dv_chain[QUOT_BITS].valid;
    out_nxt.hit      = !dv_chain[QUOT_BITS].miss;
    out_nxt.distance = '0;
    if (!dv_chain[QUOT_BITS].miss) begin
      out_nxt.distance = dv_chain[QUOT_BITS].sat ? DIST_MAX
                                                 : DIST_W'(dv_chain[QUOT_BITS].quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r.valid <= 1'b0;
      sat_r.valid <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (en) begin
      num_r <= num_nxt;
      sat_r <= sat_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

// File: design/ray_cylinder_intersect.sv
`timescale 1ns / 1ps
// Ray versus infinite z-axis cylinder intersection, fixed point, top level.
// Throughput: one ray per cycle; the 63-stage square root and 31-stage divider are
// fully pipelined, so the rate is set only by output back-pressure.
// Reset (synchronous, rst_n low) clears all valid flags and the queue; no clearing pass.
module ray_cylinder_intersect import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rci_ray_if.sink   in_ch,
  rci_hit_if.source out_ch
);

  logic        front_valid;
  front_item_t front_item;
  logic        queue_can_push;
  logic        queue_can_pop;
  front_item_t queue_item;
  logic        queue_pop;

  // Front half: products, discriminant, classification.
  rci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (front_valid),
    .item       (front_item),
    .item_ready (queue_can_push)
  );

  // Decoupling queue.
  rci_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_item),
    .can_push  (queue_can_push),
    .pop       (queue_pop),
    .pop_data  (queue_item),
    .can_pop   (queue_can_pop)
  );

  // Back half: square root, root choice, division.
  rci_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (queue_can_pop),
    .item       (queue_item),
    .item_pop   (queue_pop),
    .out_ch     (out_ch)
  );

endmodule

// File: dv/rci_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ray versus cylinder block: watches both channels, predicts hits.
// Depends on rci_pkg and the channel interfaces in rci_if.sv.
module rci_checker import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  rci_ray_if   ray,
  rci_hit_if   res,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } hit_result_t;

  hit_result_t expected_hits[$];

  // Exact integer intersection: nearest non-negative root of a*t^2 + 2*h*t + c.
  function automatic hit_result_t intersect_ray(
    input logic signed [COORD_W-1:0] dx, dy, ox, oy,
    input logic [RADIUS_W-1:0] r
  );
    logic signed [65:0] sdx, sdy, sox, soy, h, cr;
    logic [63:0]  a, hmag, xmag, r2, s, cand;
    logic [125:0] ar2, x2, disc;
    logic [127:0] sq;
    logic [65:0]  num;
    logic [95:0]  quot;
    hit_result_t  hr;
    hr = '0;
    sdx = dx;
    sdy = dy;
    sox = ox;
    soy = oy;
    a = 64'(sdx * sdx + sdy * sdy);
    // A zero direction never meets the side wall.
    if (a == 0) return hr;
    h  = sox * sdx + soy * sdy;
    cr = sox * sdy - soy * sdx;
    hmag = (h < 0) ? 64'(-h) : 64'(h);
    xmag = (cr < 0) ? 64'(-cr) : 64'(cr);
    r2   = 64'(r) * 64'(r);
    ar2  = 126'(a) * 126'(r2);
    x2   = 126'(xmag) * 126'(xmag);
    if (ar2 < x2) return hr;
    disc = ar2 - x2;
    s = '0;
    for (int b = 62; b >= 0; b--) begin
      cand = s | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= 128'(disc)) s = cand;
    end
    // Pick the near root if it is not negative, else the far one.
    if (h <= 0) begin
      num = (hmag >= s) ? 66'(hmag - s) : 66'(hmag) + 66'(s);
    end else if (s >= hmag) begin
      num = 66'(s - hmag);
    end else begin
      return hr;
    end
    quot = (96'(num) << FRAC_BITS) / 96'(a);
    hr.hit = 1'b1;
    hr.distance = (quot > 96'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
    return hr;
  endfunction

  // Predict on each accepted ray, compare on each accepted hit transaction.
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (ray.valid && ray.ready)
        expected_hits.push_back(intersect_ray(ray.dir_x, ray.dir_y, ray.orig_x,
                                              ray.orig_y, ray.radius));
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result hit=%0b distance=%0d", $time, res.hit,
                   res.distance);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit !== res.hit || want.distance !== res.distance) begin
            $display("%0t: mismatch expected hit=%0b distance=%0d, got hit=%0b distance=%0d",
                     $time, want.hit, want.distance, res.hit, res.distance);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_hits.size();
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the ray versus cylinder testbench: clock, reset, ray stimulus and verdict.
// Depends on rci_pkg, rci_if.sv, the block itself and rci_checker.
module testbench;

  localparam int ONE       = 65536;
  localparam int IDLE_MAX  = 20000;
  localparam int DRAIN     = 300;
  localparam int PHASE_LEN = 430;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   quiet_cycles;
  bit   want_stall;

  rci_ray_if ray_ch ();
  rci_hit_if hit_ch ();

  ray_cylinder_intersect u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ray_ch),
    .out_ch (hit_ch)
  );

  rci_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ray        (ray_ch),
    .res        (hit_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    hit_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_stall) begin
        hit_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        want_stall = 1'b0;
      end
      hit_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_MAX) begin
      $display("[ray_cylinder_intersect] ERROR");
      $finish;
    end
  end

  // Offer one ray, with random gaps beforehand, and wait until it is taken.
  task automatic send_ray(input logic [31:0] dx, dy, ox, oy, input logic [30:0] r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ray_ch.valid  <= 1'b1;
    ray_ch.dir_x  <= dx;
    ray_ch.dir_y  <= dy;
    ray_ch.orig_x <= ox;
    ray_ch.orig_y <= oy;
    ray_ch.radius <= r;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
  endtask

  function automatic int sym_rand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly geometry that hits or grazes; the rest is full-range and corner values.
  task automatic send_random_ray();
    int r, span, dspan;
    case ($urandom_range(9))
      0, 1: send_ray($urandom, $urandom, $urandom, $urandom, 31'($urandom));
      2, 3: send_ray(edge_word(), edge_word(), edge_word(), edge_word(),
                     31'(edge_word()));
      default: begin
        r = $urandom_range(1, 1 << $urandom_range(2, 22));
        span = 3 * r;
        dspan = 1 << $urandom_range(0, 22);
        send_ray(sym_rand(dspan), sym_rand(dspan), sym_rand(span), sym_rand(span),
                 31'(r));
      end
    endcase
  endtask

  initial begin
    ray_ch.valid  = 1'b0;
    ray_ch.dir_x  = '0;
    ray_ch.dir_y  = '0;
    ray_ch.orig_x = '0;
    ray_ch.orig_y = '0;
    ray_ch.radius = '0;
    want_stall    = 1'b0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 86;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases.
    send_ray(0, 0, 0, 0, 31'(ONE));                  // zero direction
    send_ray(ONE, 0, 5 * ONE, 0, 31'(ONE));          // both roots behind
    send_ray(-ONE, 0, 5 * ONE, 0, 31'(ONE));         // plain hit from outside
    send_ray(ONE, ONE, 0, 0, 31'(2 * ONE));          // origin inside, far root
    send_ray(ONE, 0, 0, 5 * ONE, 31'(ONE));          // negative discriminant
    send_ray(ONE, 0, -5 * ONE, ONE, 31'(ONE));       // tangent
    send_ray(ONE, 0, ONE, 0, 31'(ONE));              // on surface, heading out
    send_ray(-ONE, 0, ONE, 0, 31'(ONE));             // on surface, heading in
    send_ray(1, 0, 32'h8000_0000, 0, 31'(ONE));      // distance saturates
    send_ray(0, 1, 0, 32'h8000_0000, 31'h7FFF_FFFF); // origin just outside, near hit
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
    send_ray(ONE, 0, 0, 0, 31'd0);                   // zero radius on the axis
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 31'h7FFF_FFFF);
    send_ray(3 * ONE, -4 * ONE, 7 * ONE, 2 * ONE, 31'(3 * ONE));

    // Random phases with different idling on each side.
    repeat (PHASE_LEN) send_random_ray();
    tx_idle_pct = 86;
    rx_idle_pct = 14;
    repeat (PHASE_LEN) send_random_ray();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    want_stall  = 1'b1;
    repeat (PHASE_LEN) send_random_ray();
    @(negedge clk);
    ray_ch.valid <= 1'b0;

    // Drain, then let the outputs settle before the verdict.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ray_cylinder_intersect] OK");
    else
      $display("[ray_cylinder_intersect] ERROR");
    $finish;
  end

endmodule

// File: files.f
design/rci_pkg.sv
design/rci_if.sv
design/rci_front.sv
design/rci_fifo.sv
design/rci_back.sv
design/ray_cylinder_intersect.sv
dv/rci_checker.sv
dv/testbench.sv
